@@ rtl/core/timestamp_gap_monitor_defines.svh @@
// Assertion macros shared by the monitor's RTL files.
// Each macro expects clk and arst_n in scope.
`ifndef TIMESTAMP_GAP_MONITOR_DEFINES_SVH
`define TIMESTAMP_GAP_MONITOR_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define TGM_ASSERT(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication
`define TGM_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define TGM_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/tgm_pkg.sv @@
package tgm_pkg;

	// Field widths
	localparam int TS_W       = 64;
	localparam int THR_W      = 32;
	localparam int IDX_W      = 10;
	localparam int REC_W      = 11;
	localparam int VAL_W      = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 64;

	localparam int STORE_DEPTH_DEF = 1024;

	// Saturation value for stored gaps, and the all-ones word (no minimum yet)
	localparam logic [63:0] GAP_SAT_VAL = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] ALL_ONES_64 = 64'hFFFF_FFFF_FFFF_FFFF;

	// Register reset values
	localparam logic [THR_W-1:0] THR_RESET = 32'd360;
	localparam logic [TS_W-1:0]  RUN_RESET = 64'd36000000000;

	// Request codes; code 3 is a no-op
	typedef enum logic [1:0] {
		REQ_START  = 2'd0,
		REQ_SAMPLE = 2'd1,
		REQ_READ   = 2'd2
	} req_type_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 1'b0,
		REG_RUNTIME   = 1'b1
	} cfg_reg_t;

	// State after one request, handed from the update stage to the result pipeline
	typedef struct packed {
		logic            intr;
		logic            is_read;
		logic            rd_ok;
		logic [TS_W-1:0] prev_time;
		logic [TS_W-1:0] win_limit;
		logic [TS_W-1:0] count;
		logic [TS_W-1:0] total;
		logic [TS_W-1:0] min_gap;
		logic [TS_W-1:0] ovf_time;
		logic [TS_W-1:0] win_start;
	} snap_t;

	// Status fields carried down the result pipeline
	typedef struct packed {
		logic             intr;
		logic             open;
		logic [TS_W-1:0]  count;
		logic [TS_W-1:0]  total;
		logic [TS_W-1:0]  min_gap;
		logic [TS_W-1:0]  ovf_offset;
		logic [VAL_W-1:0] entry_value;
		logic             entry_valid;
		logic [REC_W-1:0] rec_count;
	} stat_t;

endpackage

@@ rtl/core/tgm_ifs.sv @@
// Request channel
interface tgm_req_if
	import tgm_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [1:0]       req_type;
	logic [TS_W-1:0]  timestamp;
	logic [IDX_W-1:0] entry_index;

	modport source (output valid, req_type, timestamp, entry_index, input ready);
	modport sink   (input valid, req_type, timestamp, entry_index, output ready);
endinterface

// Result channel
interface tgm_rsp_if
	import tgm_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             was_interruption;
	logic             window_open;
	logic [TS_W-1:0]  interrupt_count;
	logic [REC_W-1:0] recorded_count;
	logic [TS_W-1:0]  adjusted_total_ticks;
	logic [TS_W-1:0]  min_loop_ticks;
	logic [TS_W-1:0]  overflow_offset;
	logic [VAL_W-1:0] entry_value;
	logic             entry_valid;

	modport source (output valid, was_interruption, window_open, interrupt_count,
		recorded_count, adjusted_total_ticks, min_loop_ticks, overflow_offset,
		entry_value, entry_valid, input ready);
	modport sink   (input valid, was_interruption, window_open, interrupt_count,
		recorded_count, adjusted_total_ticks, min_loop_ticks, overflow_offset,
		entry_value, entry_valid, output ready);
endinterface

@@ rtl/core/timestamp_gap_monitor.sv @@
// Timestamp gap monitor.
// req channel: start (opens a window of runtime_ticks at its timestamp),
// sample (gap to the previous timestamp, counted as an interruption above
// threshold_ticks and stored while the store has room), read (stored gap
// minus the minimum gap). Every request gives exactly one result on rsp,
// in order, with the counters as they stand after that request.
// Configuration: cfg_we/cfg_idx/cfg_wdata, index 0 threshold_ticks,
// index 1 runtime_ticks; write only while no request is in flight.
// Throughput: one request per cycle while rsp is not stalled. State is
// updated in the accept cycle, so back-to-back samples see each other's
// effect with no bubble. Results reach rsp through the store's registered
// read and the three-stage min*count product ahead of the floored subtract.
// Reset: counters cleared, window closed, registers at their defaults; the
// gap store is not cleared, entries are only visible below recorded_count.
// Stall: when rsp.ready is low with a result waiting, the whole pipeline
// holds and req.ready drops in the same cycle; nothing is lost or repeated.
`include "timestamp_gap_monitor_defines.svh"

module timestamp_gap_monitor
	import tgm_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	tgm_req_if.sink               req,
	tgm_rsp_if.source             rsp
);

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic             acc, adv, ram_we, out_valid;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [VAL_W-1:0] ram_wdata, ram_rdata;
	logic [TS_W-1:0]  out_adj;
	snap_t            snap;
	stat_t            out_stat;

	// Request handshake
	assign req.ready = adv;
	assign acc       = req.valid && adv;

	tgm_update #(.STORE_DEPTH(STORE_DEPTH)) u_update (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.acc         (acc),
		.req_type    (req.req_type),
		.timestamp   (req.timestamp),
		.entry_index (req.entry_index),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr   (ram_raddr),
		.snap        (snap)
	);

	tgm_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (acc),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tgm_result #(.STORE_DEPTH(STORE_DEPTH)) u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.snap      (snap),
		.ram_rdata (ram_rdata),
		.out_ready (rsp.ready),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stat  (out_stat),
		.out_adj   (out_adj)
	);

	// Result channel
	assign rsp.valid                = out_valid;
	assign rsp.was_interruption     = out_stat.intr;
	assign rsp.window_open          = out_stat.open;
	assign rsp.interrupt_count      = out_stat.count;
	assign rsp.recorded_count       = out_stat.rec_count;
	assign rsp.adjusted_total_ticks = out_adj;
	assign rsp.min_loop_ticks       = out_stat.min_gap;
	assign rsp.overflow_offset      = out_stat.ovf_offset;
	assign rsp.entry_value          = out_stat.entry_value;
	assign rsp.entry_valid          = out_stat.entry_valid;

	`TGM_ASSERT(a_ready_only_when_full, req.ready || rsp.valid, "request stalled with no result waiting")
	`TGM_ASSERT_IMP(a_zero_count_status, rsp.valid && rsp.interrupt_count == '0, rsp.adjusted_total_ticks == '0 && rsp.recorded_count == '0 && rsp.overflow_offset == '0, "status nonzero with no interruptions")
	`TGM_ASSERT_IMP(a_read_result, rsp.valid && rsp.entry_valid, rsp.recorded_count != '0 && !rsp.was_interruption, "bad read result")

endmodule

@@ rtl/core/tgm_ram.sv @@
// Simple dual-port RAM, one write and one registered read port
module tgm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/tgm_update.sv @@
`include "timestamp_gap_monitor_defines.svh"

// Window and gap state: updated in the cycle a request is accepted,
// interruption gaps written to the store at the running count.
module tgm_update
	import tgm_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF,
	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  acc,
	input  logic [1:0]            req_type,
	input  logic [TS_W-1:0]       timestamp,
	input  logic [IDX_W-1:0]      entry_index,
	output logic                  ram_we,
	output logic [AW-1:0]         ram_waddr,
	output logic [VAL_W-1:0]      ram_wdata,
	output logic [AW-1:0]         ram_raddr,
	output snap_t                 snap
);

	localparam logic [TS_W-1:0] DEPTH64 = TS_W'(STORE_DEPTH);

	logic [THR_W-1:0] thr_q;
	logic [TS_W-1:0]  run_q;
	logic [TS_W-1:0]  win_start_q, win_limit_q, prev_q;
	logic             first_q;
	logic [TS_W-1:0]  gap_count_q, gap_total_q, ovf_time_q, smallest_q;

	logic [TS_W-1:0]  win_start_n, win_limit_n, prev_n;
	logic             first_n;
	logic [TS_W-1:0]  gap_count_n, gap_total_n, ovf_time_n, smallest_n;

	logic             open_now, is_start, sample_ok, intr_hit;
	logic [TS_W-1:0]  gap, idx64, rec_now;

	// Gap and window checks against current state
	assign open_now  = prev_q < win_limit_q;
	assign gap       = timestamp - prev_q;
	assign is_start  = acc && (req_type == REQ_START);
	assign sample_ok = acc && (req_type == REQ_SAMPLE) && open_now;
	assign intr_hit  = sample_ok && (gap > {32'b0, thr_q});

	// Store write, saturated to 32 bits
	assign ram_we    = intr_hit && (gap_count_q < DEPTH64);
	assign ram_waddr = gap_count_q[AW-1:0];
	assign ram_wdata = (gap > GAP_SAT_VAL) ? GAP_SAT_VAL[VAL_W-1:0] : gap[VAL_W-1:0];

	// Store read for read requests
	assign idx64     = TS_W'(entry_index);
	assign ram_raddr = idx64[AW-1:0];
	assign rec_now   = (gap_count_q < DEPTH64) ? gap_count_q : DEPTH64;

	// Next state
	always_comb begin
		win_start_n = win_start_q;
		win_limit_n = win_limit_q;
		prev_n      = prev_q;
		first_n     = first_q;
		gap_count_n = gap_count_q;
		gap_total_n = gap_total_q;
		ovf_time_n  = ovf_time_q;
		smallest_n  = smallest_q;
		if (is_start) begin
			win_start_n = timestamp;
			win_limit_n = timestamp + run_q;
			prev_n      = timestamp;
			first_n     = 1'b1;
			gap_count_n = '0;
			gap_total_n = '0;
			ovf_time_n  = '0;
			smallest_n  = ALL_ONES_64;
		end else if (sample_ok) begin
			prev_n = timestamp;
			if (intr_hit) begin
				gap_total_n = gap_total_q + gap;
				if (gap_count_q == DEPTH64) begin
					ovf_time_n = timestamp;
				end
				if (gap_count_q != ALL_ONES_64) begin
					gap_count_n = gap_count_q + 64'd1;
				end
			end
			if (first_q) begin
				first_n = 1'b0;
			end else if (gap < smallest_q) begin
				smallest_n = gap;
			end
		end
	end

	// Snapshot of the state after this request
	always_comb begin
		snap.intr      = intr_hit;
		snap.is_read   = req_type == REQ_READ;
		snap.rd_ok     = idx64 < rec_now;
		snap.prev_time = prev_n;
		snap.win_limit = win_limit_n;
		snap.count     = gap_count_n;
		snap.total     = gap_total_n;
		snap.min_gap   = (smallest_n == ALL_ONES_64) ? '0 : smallest_n;
		snap.ovf_time  = ovf_time_n;
		snap.win_start = win_start_n;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THR_RESET;
			run_q       <= RUN_RESET;
			win_start_q <= '0;
			win_limit_q <= '0;
			prev_q      <= '0;
			first_q     <= 1'b1;
			gap_count_q <= '0;
			gap_total_q <= '0;
			ovf_time_q  <= '0;
			smallest_q  <= ALL_ONES_64;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_THRESHOLD: thr_q <= cfg_wdata[THR_W-1:0];
					REG_RUNTIME:   run_q <= cfg_wdata;
				endcase
			end
			win_start_q <= win_start_n;
			win_limit_q <= win_limit_n;
			prev_q      <= prev_n;
			first_q     <= first_n;
			gap_count_q <= gap_count_n;
			gap_total_q <= gap_total_n;
			ovf_time_q  <= ovf_time_n;
			smallest_q  <= smallest_n;
		end
	end

	`TGM_ASSERT_NXT(a_start_clears, is_start,
		gap_count_q == '0 && smallest_q == ALL_ONES_64 && first_q,
		"start did not clear gap state")
	`TGM_ASSERT_IMP(a_write_from_sample, ram_we,
		acc && req_type == REQ_SAMPLE && open_now,
		"store write without an open-window sample")
	`TGM_ASSERT_NXT(a_write_counts, ram_we, gap_count_q != '0,
		"store write did not advance the count")

endmodule

@@ rtl/core/tgm_result.sv @@
// Result pipeline: store read data, min*count partial products, product
// assembly, floored subtract, output register. Stalls as a whole.
module tgm_result
	import tgm_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  snap_t            snap,
	input  logic [VAL_W-1:0] ram_rdata,
	input  logic             out_ready,
	output logic             adv,
	output logic             out_valid,
	output stat_t            out_stat,
	output logic [TS_W-1:0]  out_adj
);

	localparam logic [TS_W-1:0] DEPTH64 = TS_W'(STORE_DEPTH);

	logic             v_s1, v_s2, v_s3, v_s4, out_v_q;
	snap_t            snap_s1;
	stat_t            st_c, st_s2, st_s3, st_s4, out_st_q;
	logic [TS_W-1:0]  rec64, rd64, diff64;
	logic [31:0]      ml, mh, cl, ch;
	logic [63:0]      pp_ll_c, pp_lh_c, pp_hl_c;
	logic [63:0]      pp_ll_s2, pp_lh_s2, pp_hl_s2, pp_ll_s3;
	logic             hh_s2, hh_s3;
	logic [64:0]      mid_s3;
	logic [96:0]      full_c;
	logic [TS_W-1:0]  prod_s4, out_adj_q;
	logic             povf_s4;

	assign adv = !out_v_q || out_ready;

	// Stage 1: register the snapshot; store read data is registered alongside it
	always_ff @(posedge clk) begin
		if (adv) begin
			snap_s1 <= snap;
		end
	end

	// Status fields from the snapshot and store read data
	assign rec64  = (snap_s1.count < DEPTH64) ? snap_s1.count : DEPTH64;
	assign rd64   = TS_W'(ram_rdata);
	assign diff64 = (rd64 > snap_s1.min_gap) ? (rd64 - snap_s1.min_gap) : '0;

	always_comb begin
		st_c.intr        = snap_s1.intr;
		st_c.open        = snap_s1.prev_time < snap_s1.win_limit;
		st_c.count       = snap_s1.count;
		st_c.total       = snap_s1.total;
		st_c.min_gap     = snap_s1.min_gap;
		st_c.ovf_offset  = (snap_s1.count > DEPTH64) ?
			(snap_s1.ovf_time - snap_s1.win_start) : '0;
		st_c.entry_valid = snap_s1.is_read && snap_s1.rd_ok;
		st_c.entry_value = st_c.entry_valid ? diff64[VAL_W-1:0] : '0;
		st_c.rec_count   = rec64[REC_W-1:0];
	end

	// 32x32 partial products of min * count; high*high only needs a zero test
	assign ml      = snap_s1.min_gap[31:0];
	assign mh      = snap_s1.min_gap[63:32];
	assign cl      = snap_s1.count[31:0];
	assign ch      = snap_s1.count[63:32];
	assign pp_ll_c = {32'b0, ml} * {32'b0, cl};
	assign pp_lh_c = {32'b0, ml} * {32'b0, ch};
	assign pp_hl_c = {32'b0, mh} * {32'b0, cl};

	// Stages 2..4 and output register
	assign full_c = {33'b0, pp_ll_s3} + {mid_s3, 32'b0};

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s2    <= st_c;
			pp_ll_s2 <= pp_ll_c;
			pp_lh_s2 <= pp_lh_c;
			pp_hl_s2 <= pp_hl_c;
			hh_s2    <= (|mh) && (|ch);

			st_s3    <= st_s2;
			mid_s3   <= {1'b0, pp_lh_s2} + {1'b0, pp_hl_s2};
			pp_ll_s3 <= pp_ll_s2;
			hh_s3    <= hh_s2;

			st_s4    <= st_s3;
			prod_s4  <= full_c[63:0];
			povf_s4  <= hh_s3 || (|full_c[96:64]);

			out_st_q  <= st_s4;
			out_adj_q <= (povf_s4 || (st_s4.total <= prod_s4)) ? '0 :
				(st_s4.total - prod_s4);
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= acc;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			out_v_q <= v_s4;
		end
	end

	assign out_valid = out_v_q;
	assign out_stat  = out_st_q;
	assign out_adj   = out_adj_q;

endmodule
